### rtl/lpfe_pkg.sv
// ----------------------------------------------------------------------------
// lpfe_pkg: shared types and constants of the frame extractor
// Result record, header-hold codes and queue sizing.
// ----------------------------------------------------------------------------
package lpfe_pkg;

  localparam logic [15:0] MaxPayloadRst = 16'd2048;

  localparam logic KindHeader  = 1'b0;
  localparam logic KindPayload = 1'b1;

  // Number of header bytes held while hunting for a frame.
  localparam logic [1:0] HeldNone = 2'd0;
  localparam logic [1:0] HeldOne  = 2'd1;
  localparam logic [1:0] HeldTwo  = 2'd2;

  localparam int QDepth = 2;
  localparam int QPtrW  = (QDepth > 1) ? $clog2(QDepth) : 1;
  localparam int QCntW  = $clog2(QDepth + 1);

  typedef struct packed {
    logic        item_kind;
    logic [7:0]  command;
    logic [15:0] payload_length;
    logic [7:0]  data_byte;
    logic        last_of_frame;
  } lpfe_result_t;

endpackage

### rtl/lpfe_front.sv
// ----------------------------------------------------------------------------
// lpfe_front: byte classifier and frame tracker
// Holds header bytes, checks the claimed length and produces result records.
// ----------------------------------------------------------------------------
module lpfe_front (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  accept_i,
  input  logic [7:0]            rx_byte_i,
  input  logic                  cfg_we_i,
  input  logic [15:0]           cfg_wdata_i,
  output logic                  res_valid_o,
  output lpfe_pkg::lpfe_result_t res_o
);
  import lpfe_pkg::*;

  logic [15:0] max_payload_q, max_payload_d;
  logic [15:0] held_q, held_d;
  logic [1:0]  held_count_q, held_count_d;
  logic        in_payload_q, in_payload_d;
  logic [15:0] remaining_q, remaining_d;
  logic [7:0]  frame_command_q, frame_command_d;
  logic [15:0] frame_length_q, frame_length_d;
  logic [15:0] plen;

  assign max_payload_d = cfg_we_i ? cfg_wdata_i : max_payload_q;
  assign plen          = {rx_byte_i, held_q[15:8]};

  always_comb begin
    held_d          = held_q;
    held_count_d    = held_count_q;
    in_payload_d    = in_payload_q;
    remaining_d     = remaining_q;
    frame_command_d = frame_command_q;
    frame_length_d  = frame_length_q;
    res_valid_o     = 1'b0;
    res_o           = '0;
    if (accept_i) begin
      if (in_payload_q) begin
        res_valid_o          = 1'b1;
        res_o.item_kind      = KindPayload;
        res_o.command        = frame_command_q;
        res_o.payload_length = frame_length_q;
        res_o.data_byte      = rx_byte_i;
        res_o.last_of_frame  = (remaining_q <= 16'd1);
        if (remaining_q <= 16'd1) begin
          in_payload_d = 1'b0;
          remaining_d  = '0;
        end else begin
          remaining_d = remaining_q - 16'd1;
        end
      end else begin
        unique case (held_count_q)
          HeldNone: begin
            held_d       = {8'h00, rx_byte_i};
            held_count_d = HeldOne;
          end
          HeldOne: begin
            held_d       = {rx_byte_i, held_q[7:0]};
            held_count_d = HeldTwo;
          end
          default: begin
            if (plen > max_payload_q) begin
              // Too long: drop the oldest byte and slide the window.
              held_d       = plen;
              held_count_d = HeldTwo;
            end else begin
              held_d               = '0;
              held_count_d         = HeldNone;
              frame_command_d      = held_q[7:0];
              frame_length_d       = plen;
              in_payload_d         = (plen != 16'd0);
              remaining_d          = plen;
              res_valid_o          = 1'b1;
              res_o.item_kind      = KindHeader;
              res_o.command        = held_q[7:0];
              res_o.payload_length = plen;
              res_o.data_byte      = 8'h00;
              res_o.last_of_frame  = (plen == 16'd0);
            end
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_payload_q   <= MaxPayloadRst;
      held_q          <= '0;
      held_count_q    <= HeldNone;
      in_payload_q    <= 1'b0;
      remaining_q     <= '0;
      frame_command_q <= '0;
      frame_length_q  <= '0;
    end else begin
      max_payload_q   <= max_payload_d;
      held_q          <= held_d;
      held_count_q    <= held_count_d;
      in_payload_q    <= in_payload_d;
      remaining_q     <= remaining_d;
      frame_command_q <= frame_command_d;
      frame_length_q  <= frame_length_d;
    end
  end

endmodule

### rtl/lpfe_queue.sv
// ----------------------------------------------------------------------------
// lpfe_queue: result queue
// Small register queue that holds result records until they are popped.
// ----------------------------------------------------------------------------
module lpfe_queue (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  wr_en_i,
  input  lpfe_pkg::lpfe_result_t wr_data_i,
  input  logic                  rd_en_i,
  output lpfe_pkg::lpfe_result_t rd_data_o,
  output logic                  full_o,
  output logic                  empty_o
);
  import lpfe_pkg::*;

  lpfe_result_t     entry_q [QDepth];
  logic [QPtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCntW-1:0] count_q, count_d;
  logic             do_wr, do_rd;

  assign full_o    = (count_q == QCntW'(QDepth));
  assign empty_o   = (count_q == '0);
  assign do_wr     = wr_en_i && !full_o;
  assign do_rd     = rd_en_i && !empty_o;
  assign rd_data_o = entry_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_wr) begin
      wr_ptr_d = (wr_ptr_q == QPtrW'(QDepth - 1)) ? '0 : wr_ptr_q + QPtrW'(1);
    end
    if (do_rd) begin
      rd_ptr_d = (rd_ptr_q == QPtrW'(QDepth - 1)) ? '0 : rd_ptr_q + QPtrW'(1);
    end
    if (do_wr && !do_rd) begin
      count_d = count_q + QCntW'(1);
    end else if (do_rd && !do_wr) begin
      count_d = count_q - QCntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      entry_q[wr_ptr_q] <= wr_data_i;
    end
  end

endmodule

### rtl/length_prefixed_frame_extractor_top.sv
// A result is written into the result queue and drives the outputs once it is at the head.
// Throughput: one byte per cycle unless the queue is full; the header check is combinational.
// A two-entry result queue lets input transfers continue while one result waits to be popped.
// Reset (asynchronous, active low) clears the frame state and empties the queue;
// max_payload returns to 2048.
// ----------------------------------------------------------------------------
// length_prefixed_frame_extractor_top: length-prefixed frame extractor
// Cuts a byte stream into command/length headers and payload bytes.
// ----------------------------------------------------------------------------
module length_prefixed_frame_extractor_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  rx_byte_i,
  output logic        empty,
  input  logic        pop,
  output logic        item_kind_o,
  output logic [7:0]  command_o,
  output logic [15:0] payload_length_o,
  output logic [7:0]  data_byte_o,
  output logic        last_of_frame_o,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i
);
  import lpfe_pkg::*;

  logic         accept;
  logic         res_valid;
  lpfe_result_t res;
  lpfe_result_t head;

  assign accept = push && !full;

  lpfe_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .rx_byte_i   (rx_byte_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  lpfe_queue u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (res_valid),
    .wr_data_i (res),
    .rd_en_i   (pop),
    .rd_data_o (head),
    .full_o    (full),
    .empty_o   (empty)
  );

  assign item_kind_o      = head.item_kind;
  assign command_o        = head.command;
  assign payload_length_o = head.payload_length;
  assign data_byte_o      = head.data_byte;
  assign last_of_frame_o  = head.last_of_frame;

`ifndef ASSERT_OFF
  a_full_empty_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(full && empty))
    else $error("queue reports full and empty together");

  a_head_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> !empty)
    else $error("waiting result lost without a pop");

  a_header_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && item_kind_o == KindHeader) |->
      (last_of_frame_o == (payload_length_o == 16'd0)))
    else $error("header last flag disagrees with its length");

  a_header_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && item_kind_o == KindHeader) |-> (data_byte_o == 8'h00))
    else $error("header result carries a data byte");
`endif

endmodule
